// ===== rtl/core/msd_pkg.sv =====
// Package for the map short-link decoder: character codes, limits and shared types.
package msd_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 32;
  localparam int unsigned OUT_ANGLE_W    = 32;
  localparam int unsigned ZOOM_W         = 5;

  localparam logic [7:0] CHR_UP_A   = 8'h41;
  localparam logic [7:0] CHR_UP_Z   = 8'h5A;
  localparam logic [7:0] CHR_LO_A   = 8'h61;
  localparam logic [7:0] CHR_LO_Z   = 8'h7A;
  localparam logic [7:0] CHR_DIG_0  = 8'h30;
  localparam logic [7:0] CHR_DIG_9  = 8'h39;
  localparam logic [7:0] CHR_USCORE = 8'h5F;
  localparam logic [7:0] CHR_AT     = 8'h40;

  localparam logic [7:0] OFS_LOWER  = 8'd26;
  localparam logic [7:0] OFS_DIGIT  = 8'd52;
  localparam logic [5:0] SYM_USCORE = 6'd62;
  localparam logic [5:0] SYM_AT     = 6'd63;

  localparam int unsigned ZOOM_BIAS     = 8;
  localparam int unsigned ZOOM_MAX      = 20;
  localparam int unsigned ZOOM_FALLBACK = 15;
  localparam logic [1:0]  MARK_PERIOD   = 2'd3;

  typedef struct packed {
    logic       is_sym;
    logic [5:0] value;
  } msd_sym_t;

  typedef struct packed {
    logic signed [OUT_ANGLE_W-1:0] lon_angle;
    logic signed [OUT_ANGLE_W-1:0] lat_angle;
    logic [ZOOM_W-1:0]             zoom_level;
    logic                          status;
  } msd_res_t;

endpackage

// ===== rtl/core/map_shortlink_decoder.sv =====
// A final character goes through the input register, then the result register.
// Throughput: one character per cycle; set by the single pass from input register to
// result register, which stalls only when a final character meets a held result.
// Reset: asynchronous, active low; clears both valid flags, the accumulators, the bit
// and mark counters and the overflow flag. No clearing pass is needed.
// Top level of the map short-link decoder.
module map_shortlink_decoder #(
  parameter int unsigned ANGLE_BITS = msd_pkg::ANGLE_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [7:0]                               char_code_i,
  input  logic                                     last_char_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [msd_pkg::OUT_ANGLE_W-1:0]   lon_angle_o,
  output logic signed [msd_pkg::OUT_ANGLE_W-1:0]   lat_angle_o,
  output logic [msd_pkg::ZOOM_W-1:0]               zoom_level_o,
  output logic                                     status_o
);
  import msd_pkg::*;

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       adv;
  logic       in_fire;
  logic       out_valid_q, out_valid_d;
  msd_res_t   res;
  msd_res_t   res_q;

  assign adv        = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  msd_state #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .char_code_i (char_q),
    .last_char_i (last_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lon_angle_o  = res_q.lon_angle;
  assign lat_angle_o  = res_q.lat_angle;
  assign zoom_level_o = res_q.zoom_level;
  assign status_o     = res_q.status;

`ifndef SYNTH
  a_mid_never_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !last_q |-> in_ready_o)
    else $error("non-final character stalled");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last_q |=> out_valid_q)
    else $error("final character produced no result");

  a_zoom_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> zoom_level_o >= ZOOM_W'(1) && zoom_level_o <= ZOOM_W'(ZOOM_MAX))
    else $error("zoom out of range");
`endif

endmodule

// ===== rtl/core/msd_symbol.sv =====
// Character classifier: maps a code character to its six-bit symbol or flags a mark.
module msd_symbol (
  input  logic [7:0]       char_code_i,
  output msd_pkg::msd_sym_t sym_o
);
  import msd_pkg::*;

  always_comb begin
    sym_o.is_sym = 1'b1;
    sym_o.value  = '0;
    if (char_code_i >= CHR_UP_A && char_code_i <= CHR_UP_Z) begin
      sym_o.value = 6'(char_code_i - CHR_UP_A);
    end else if (char_code_i >= CHR_LO_A && char_code_i <= CHR_LO_Z) begin
      sym_o.value = 6'(char_code_i - CHR_LO_A + OFS_LOWER);
    end else if (char_code_i >= CHR_DIG_0 && char_code_i <= CHR_DIG_9) begin
      sym_o.value = 6'(char_code_i - CHR_DIG_0 + OFS_DIGIT);
    end else if (char_code_i == CHR_USCORE) begin
      sym_o.value = SYM_USCORE;
    end else if (char_code_i == CHR_AT) begin
      sym_o.value = SYM_AT;
    end else begin
      sym_o.is_sym = 1'b0;
    end
  end

endmodule

// ===== rtl/core/msd_state.sv =====
// Decoder state: coordinate accumulators, bit and mark counters, and result formatting.
module msd_state #(
  parameter int unsigned ANGLE_BITS = msd_pkg::ANGLE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [7:0]        char_code_i,
  input  logic              last_char_i,
  output msd_pkg::msd_res_t res_o
);
  import msd_pkg::*;

  localparam int unsigned MAX_BITS = 3 * (ANGLE_BITS / 3);
  localparam int unsigned BC_W     = $clog2(MAX_BITS + 1);
  localparam int unsigned SH_W     = $clog2(ANGLE_BITS + 1);

  msd_sym_t sym;

  logic [ANGLE_BITS-1:0] lon_q, lon_d, lon_upd, lon_sh, lon_fx;
  logic [ANGLE_BITS-1:0] lat_q, lat_d, lat_upd, lat_sh, lat_fx;
  logic [BC_W-1:0]       bc_q, bc_d, bc_upd;
  logic [1:0]            mod3_q, mod3_d, mod3_upd;
  logic                  marked_q, marked_d, marked_upd;
  logic                  ovf_q, ovf_d, ovf_upd;
  logic [SH_W-1:0]       shamt;
  logic [6:0]            zoom_raw;
  logic signed [6:0]     zoom_s;

  msd_symbol u_symbol (
    .char_code_i (char_code_i),
    .sym_o       (sym)
  );

  always_comb begin
    lon_upd    = lon_q;
    lat_upd    = lat_q;
    bc_upd     = bc_q;
    mod3_upd   = mod3_q;
    marked_upd = marked_q;
    ovf_upd    = ovf_q;
    if (!sym.is_sym) begin
      marked_upd = 1'b1;
      mod3_upd   = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
    end else if (bc_q == BC_W'(MAX_BITS)) begin
      ovf_upd = 1'b1;
    end else begin
      lon_upd = {lon_q[ANGLE_BITS-4:0], sym.value[5], sym.value[3], sym.value[1]};
      lat_upd = {lat_q[ANGLE_BITS-4:0], sym.value[4], sym.value[2], sym.value[0]};
      bc_upd  = bc_q + BC_W'(3);
    end

    if (last_char_i) begin
      lon_d    = '0;
      lat_d    = '0;
      bc_d     = '0;
      mod3_d   = '0;
      marked_d = 1'b0;
      ovf_d    = 1'b0;
    end else begin
      lon_d    = lon_upd;
      lat_d    = lat_upd;
      bc_d     = bc_upd;
      mod3_d   = mod3_upd;
      marked_d = marked_upd;
      ovf_d    = ovf_upd;
    end
  end

  always_comb begin
    shamt  = SH_W'(ANGLE_BITS) - SH_W'(bc_upd);
    lon_sh = lon_upd << shamt;
    lat_sh = lat_upd << shamt;
    lon_fx = lon_sh ^ {1'b1, {(ANGLE_BITS-1){1'b0}}};
    lat_fx = lat_sh ^ {1'b1, {(ANGLE_BITS-1){1'b0}}};

    zoom_raw = 7'(bc_upd) - 7'(ZOOM_BIAS);
    if (marked_upd) begin
      zoom_raw = zoom_raw - 7'(MARK_PERIOD - mod3_upd);
    end
    zoom_s = signed'(zoom_raw);

    res_o.lon_angle = OUT_ANGLE_W'($signed(lon_fx));
    res_o.lat_angle = OUT_ANGLE_W'($signed(lat_fx));
    res_o.status    = ovf_upd;
    if (zoom_s > $signed(7'(ZOOM_MAX))) begin
      res_o.zoom_level = ZOOM_W'(ZOOM_MAX);
    end else if (zoom_s < $signed(7'd1)) begin
      res_o.zoom_level = ZOOM_W'(ZOOM_FALLBACK);
    end else begin
      res_o.zoom_level = zoom_raw[ZOOM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lon_q    <= '0;
      lat_q    <= '0;
      bc_q     <= '0;
      mod3_q   <= '0;
      marked_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else if (en_i) begin
      lon_q    <= lon_d;
      lat_q    <= lat_d;
      bc_q     <= bc_d;
      mod3_q   <= mod3_d;
      marked_q <= marked_d;
      ovf_q    <= ovf_d;
    end
  end

`ifndef SYNTH
  a_bc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= BC_W'(MAX_BITS))
    else $error("bit count beyond accumulator room");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && last_char_i |=> bc_q == '0 && !ovf_q && !marked_q && lon_q == '0 && lat_q == '0)
    else $error("state not cleared after final character");

  a_ovf_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> bc_q == BC_W'(MAX_BITS))
    else $error("overflow flagged with room left");
`endif

endmodule
